// ===== src/tpspwm_pkg.sv =====
// shared types, constants and the half-sine table of the three-phase sine pwm generator
package tpspwm_pkg;

	localparam int CMP_W     = 16;
	localparam int SINE_W    = 7;
	localparam int TABLE_LEN = 72;
	localparam int MUL_W     = 24;
	localparam int PROD_W    = 47;

	localparam logic [14:0] NUM_SAT     = 15'd9900;
	localparam logic [6:0]  DUTY_MAX    = 7'd99;
	localparam logic [8:0]  PCT_BASE    = 9'd100;
	localparam logic [12:0] RECIP_DUTY  = 13'd5243;
	localparam int          DUTY_SHIFT  = 19;
	localparam logic [23:0] RECIP_CMP   = 24'd10737419;
	localparam int          CMP_SHIFT   = 30;

	localparam logic REG_PWM_PERIOD = 1'b0;
	localparam logic REG_GATE_OFF   = 1'b1;

	localparam logic [SINE_W-1:0] HALF_SINE [TABLE_LEN] = '{
		7'd0, 7'd4, 7'd9, 7'd13, 7'd17, 7'd22, 7'd26, 7'd30, 7'd34, 7'd38, 7'd42, 7'd46,
		7'd50, 7'd54, 7'd57, 7'd61, 7'd64, 7'd68, 7'd71, 7'd74, 7'd77, 7'd79, 7'd82, 7'd84,
		7'd87, 7'd89, 7'd91, 7'd92, 7'd94, 7'd95, 7'd97, 7'd98, 7'd98, 7'd99, 7'd100,
		7'd100, 7'd100, 7'd100, 7'd100, 7'd99, 7'd98, 7'd98, 7'd97, 7'd95, 7'd94, 7'd92,
		7'd91, 7'd89, 7'd87, 7'd84, 7'd82, 7'd79, 7'd77, 7'd74, 7'd71, 7'd68, 7'd64,
		7'd61, 7'd57, 7'd54, 7'd50, 7'd46, 7'd42, 7'd38, 7'd34, 7'd30, 7'd26, 7'd22,
		7'd17, 7'd13, 7'd9, 7'd4
	};

	typedef struct packed {
		logic              start;
		logic [SINE_W-1:0] sine;
		logic signed [7:0] corr;
	} scale_req_t;

	typedef struct packed {
		logic             done;
		logic [CMP_W-1:0] cmp;
	} scale_rsp_t;

endpackage

// ===== src/tpspwm_scale_unit.sv =====
// shared multiplier sequence: corrected duty, clamp and scaling to a compare value
module tpspwm_scale_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tpspwm_pkg::scale_req_t req,
	input  logic [15:0]            pwm_period,
	output tpspwm_pkg::scale_rsp_t rsp
);
	import tpspwm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RECIP = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]        st_q;
	logic [PROD_W-1:0] prod_q;
	logic              sat_q;
	logic signed [8:0] csum;
	logic [7:0]        coef;
	logic [6:0]        duty;
	logic [MUL_W-1:0]  op_a;
	logic [MUL_W-1:0]  op_b;
	logic [2*MUL_W-1:0] product;

	assign csum = $signed({req.corr[7], req.corr}) + $signed(PCT_BASE);
	assign coef = (csum[8] || csum == 9'sd0) ? 8'd0 : csum[7:0];
	assign duty = sat_q ? DUTY_MAX : prod_q[DUTY_SHIFT+6:DUTY_SHIFT];

	always_comb begin
		case (st_q)
			ST_RECIP: begin
				op_a = MUL_W'(prod_q[14:0]);
				op_b = MUL_W'(RECIP_DUTY);
			end
			ST_SCALE: begin
				op_a = MUL_W'(pwm_period);
				op_b = MUL_W'(duty);
			end
			ST_DIV: begin
				op_a = MUL_W'(prod_q[22:0]);
				op_b = RECIP_CMP;
			end
			default: begin
				op_a = MUL_W'(req.sine);
				op_b = MUL_W'(coef);
			end
		endcase
	end

	assign product = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE:  if (req.start) st_q <= ST_RECIP;
				ST_RECIP: st_q <= ST_SCALE;
				ST_SCALE: st_q <= ST_DIV;
				ST_DIV:   st_q <= ST_DONE;
				ST_DONE:  st_q <= ST_IDLE;
				default:  st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q != ST_DONE && (st_q != ST_IDLE || req.start)) begin
			prod_q <= product[PROD_W-1:0];
		end
		if (st_q == ST_RECIP) begin
			sat_q <= (prod_q[14:0] >= NUM_SAT);
		end
	end

	assign rsp.done = (st_q == ST_DONE);
	assign rsp.cmp  = prod_q[CMP_SHIFT+CMP_W-1:CMP_SHIFT];

endmodule

// ===== src/three_phase_sine_pwm_generator.sv =====
// top level of the three-phase sine pwm generator: tick counter, phase indices, sequencer
//
// usage
//   s_* channel takes one word per time-base tick: ticks_per_step and correction_percent.
//   m_* channel gives one word per tick: step flag, six held gate compares, half-cycle
//   start mark and the phase-A index after the tick.
//   cfg_we/cfg_index/cfg_data write pwm_period (index 0) and gate_off_level (index 1);
//   write only while no tick is in flight.
// timing
//   a tick that does not step shows on m_* the cycle after it is taken, and the next
//   tick may follow at once.
//   a tick that steps runs the three phases in turn through one shared multiplier,
//   so its word shows only once the third phase is done.
//   s_tready is low while a step is worked on and while an undelivered word waits
//   with m_tready low; a stalled output holds its word.
// reset
//   counter clears, indices return to their 120 degree start points, held compares
//   clear, pwm_period returns to 1000 and gate_off_level to 0.
module three_phase_sine_pwm_generator #(
	parameter int STEPS_PER_CYCLE = 144
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ticks_per_step[15:0], correction_percent[23:16]
	input  logic [23:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// step_taken[0], phase_a_high[16:1], phase_a_low[32:17], phase_b_high[48:33],
	// phase_b_low[64:49], phase_c_high[80:65], phase_c_low[96:81], half_start[98:97],
	// phase_a_index[106:99], zero fill[111:107]
	output logic [111:0] m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);
	import tpspwm_pkg::*;

	localparam int IDX_W      = $clog2(STEPS_PER_CYCLE);
	localparam int HALF_STEPS = STEPS_PER_CYCLE / 2;
	localparam logic [7:0] IDX_LAST  = 8'(STEPS_PER_CYCLE - 1);
	localparam logic [7:0] IDX_HALF  = 8'(HALF_STEPS);
	localparam logic [7:0] IDX_A_RST = 8'(2 * STEPS_PER_CYCLE / 3);
	localparam logic [7:0] IDX_B_RST = 8'(STEPS_PER_CYCLE / 3);

	localparam logic [1:0] T_IDLE  = 2'd0;
	localparam logic [1:0] T_ISSUE = 2'd1;
	localparam logic [1:0] T_WAIT  = 2'd2;

	localparam logic [1:0] HALF_NONE   = 2'd0;
	localparam logic [1:0] HALF_FIRST  = 2'd1;
	localparam logic [1:0] HALF_SECOND = 2'd2;

	function automatic logic [SINE_W-1:0] sine_at(input int idx);
		int r;
		int pos;
		r = (idx < HALF_STEPS) ? idx : idx - HALF_STEPS;
		pos = r * TABLE_LEN / HALF_STEPS;
		if (pos >= TABLE_LEN) pos = TABLE_LEN - 1;
		return HALF_SINE[pos];
	endfunction

	logic [SINE_W-1:0] sine_rom [STEPS_PER_CYCLE];

	for (genvar g = 0; g < STEPS_PER_CYCLE; g++) begin : g_rom
		assign sine_rom[g] = sine_at(g);
	end

	function automatic logic [7:0] advance(input logic [7:0] idx);
		return (idx == IDX_LAST) ? 8'd0 : idx + 8'd1;
	endfunction

	logic [15:0]       pwm_period_q;
	logic [15:0]       gate_off_q;
	logic [15:0]       tick_q;
	logic [7:0]        idx_a_q;
	logic [7:0]        idx_b_q;
	logic [7:0]        idx_c_q;
	logic [1:0]        mark_q;
	logic [1:0]        half_q;
	logic [CMP_W-1:0]  held_q [6];
	logic signed [7:0] corr_q;
	logic [1:0]        state_q;
	logic [1:0]        ph_q;
	logic              m_tvalid_q;
	logic [111:0]      m_tdata_q;

	logic              accept;
	logic [15:0]       tick_next;
	logic              step_now;
	logic [7:0]        idx_a_next;
	logic [7:0]        sel_idx;
	logic              first_half;
	logic [CMP_W-1:0]  hi_w;
	logic [CMP_W-1:0]  lo_w;
	scale_req_t        req;
	scale_rsp_t        rsp;

	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == T_IDLE) && (!m_tvalid_q || m_tready);
	assign tick_next  = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
	assign step_now   = tick_next > s_tdata[15:0];
	assign idx_a_next = advance(idx_a_q);

	always_comb begin
		case (ph_q)
			2'd0:    sel_idx = idx_a_q;
			2'd1:    sel_idx = idx_b_q;
			default: sel_idx = idx_c_q;
		endcase
	end

	assign first_half = sel_idx < IDX_HALF;
	assign hi_w       = first_half ? rsp.cmp : gate_off_q;
	assign lo_w       = first_half ? gate_off_q : rsp.cmp;

	assign req.start = (state_q == T_ISSUE);
	assign req.sine  = sine_rom[sel_idx[IDX_W-1:0]];
	assign req.corr  = corr_q;

	tpspwm_scale_unit u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.pwm_period (pwm_period_q),
		.rsp        (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= 16'd1000;
			gate_off_q   <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PWM_PERIOD: pwm_period_q <= cfg_data;
				REG_GATE_OFF:   gate_off_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= 16'd0;
			idx_a_q    <= IDX_A_RST;
			idx_b_q    <= IDX_B_RST;
			idx_c_q    <= 8'd0;
			mark_q     <= HALF_NONE;
			half_q     <= HALF_NONE;
			state_q    <= T_IDLE;
			ph_q       <= 2'd0;
			m_tvalid_q <= 1'b0;
			for (int k = 0; k < 6; k++) held_q[k] <= '0;
		end else begin
			if ((state_q == T_IDLE && accept && !step_now)
				|| (state_q == T_WAIT && rsp.done && ph_q == 2'd2)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (step_now) begin
							tick_q  <= 16'd0;
							idx_a_q <= idx_a_next;
							idx_b_q <= advance(idx_b_q);
							idx_c_q <= advance(idx_c_q);
							ph_q    <= 2'd0;
							state_q <= T_ISSUE;
							if (idx_a_next == 8'd0 && mark_q != HALF_FIRST) begin
								mark_q <= HALF_FIRST;
								half_q <= HALF_FIRST;
							end else if (idx_a_next == IDX_HALF && mark_q != HALF_SECOND) begin
								mark_q <= HALF_SECOND;
								half_q <= HALF_SECOND;
							end else begin
								half_q <= HALF_NONE;
							end
						end else begin
							tick_q <= tick_next;
						end
					end
				end
				T_ISSUE: state_q <= T_WAIT;
				T_WAIT: begin
					if (rsp.done) begin
						held_q[{ph_q, 1'b0}] <= hi_w;
						held_q[{ph_q, 1'b1}] <= lo_w;
						if (ph_q == 2'd2) begin
							state_q <= T_IDLE;
						end else begin
							ph_q    <= ph_q + 2'd1;
							state_q <= T_ISSUE;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			corr_q <= s_tdata[23:16];
			if (!step_now) begin
				m_tdata_q <= {5'd0, idx_a_q, HALF_NONE, held_q[5], held_q[4], held_q[3],
					held_q[2], held_q[1], held_q[0], 1'b0};
			end
		end else if (state_q == T_WAIT && rsp.done && ph_q == 2'd2) begin
			m_tdata_q <= {5'd0, idx_a_q, half_q, lo_w, hi_w, held_q[3], held_q[2],
				held_q[1], held_q[0], 1'b1};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_step_hides_output: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && step_now) |=> !m_tvalid_q)
		else $error("output shown before step finished");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == T_WAIT))
		else $error("scale result outside wait state");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != 2'd3)
		else $error("phase counter out of range");

	a_half_with_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tdata_q[98:97] != HALF_NONE) |-> m_tdata_q[0])
		else $error("half-cycle mark without step");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the three-phase sine pwm generator with a class-based predictor
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tpspwm_pkg::*;

	localparam int STEPS      = 144;
	localparam int HALF       = STEPS / 2;
	localparam int SINE_LEN   = 72;
	localparam int CYCLE_MAX  = 600000;
	localparam int DRAIN_WAIT = 24;
	localparam int SHOW_MAX   = 40;

	localparam logic [6:0] SINE_PCT [SINE_LEN] = '{
		7'd0, 7'd4, 7'd9, 7'd13, 7'd17, 7'd22, 7'd26, 7'd30, 7'd34, 7'd38, 7'd42, 7'd46,
		7'd50, 7'd54, 7'd57, 7'd61, 7'd64, 7'd68, 7'd71, 7'd74, 7'd77, 7'd79, 7'd82, 7'd84,
		7'd87, 7'd89, 7'd91, 7'd92, 7'd94, 7'd95, 7'd97, 7'd98, 7'd98, 7'd99, 7'd100,
		7'd100, 7'd100, 7'd100, 7'd100, 7'd99, 7'd98, 7'd98, 7'd97, 7'd95, 7'd94, 7'd92,
		7'd91, 7'd89, 7'd87, 7'd84, 7'd82, 7'd79, 7'd77, 7'd74, 7'd71, 7'd68, 7'd64,
		7'd61, 7'd57, 7'd54, 7'd50, 7'd46, 7'd42, 7'd38, 7'd34, 7'd30, 7'd26, 7'd22,
		7'd17, 7'd13, 7'd9, 7'd4
	};

	// output word, lowest field last
	typedef struct packed {
		logic [4:0]  fill;
		logic [7:0]  a_index;
		logic [1:0]  half_start;
		logic [15:0] c_low;
		logic [15:0] c_high;
		logic [15:0] b_low;
		logic [15:0] b_high;
		logic [15:0] a_low;
		logic [15:0] a_high;
		logic        step_taken;
	} pwm_word_t;

	class sine_pwm_predictor;
		logic [15:0] pwm_period;
		logic [15:0] gate_off;
		logic [15:0] tick_count;
		int unsigned idx_a, idx_b, idx_c;
		logic [1:0]  half_mark;
		logic [15:0] held [6];
		pwm_word_t   expected_words [$];
		int          errors, words_checked, ticks_taken, steps, halves, settings;

		function new();
			pwm_period = 16'd1000;
			gate_off = 16'd0;
			tick_count = 16'd0;
			idx_a = 2 * STEPS / 3;
			idx_b = STEPS / 3;
			idx_c = 0;
			half_mark = 2'd0;
			foreach (held[k]) held[k] = 16'd0;
			settings = 1;
		endfunction

		function void write_reg(logic idx, logic [15:0] value);
			if (idx == REG_PWM_PERIOD) begin
				pwm_period = value;
				settings++;
			end else begin
				gate_off = value;
			end
		endfunction

		function int unsigned next_index(int unsigned idx);
			return (idx < STEPS - 1) ? idx + 1 : 0;
		endfunction

		function logic [15:0] duty_compare(int unsigned idx, logic signed [7:0] corr);
			int r, pos, num, v;
			r = (idx < HALF) ? idx : idx - HALF;
			pos = r * SINE_LEN / HALF;
			if (pos > SINE_LEN - 1) pos = SINE_LEN - 1;
			num = int'(SINE_PCT[pos]) * (100 + int'(corr));
			v = (num < 0) ? 0 : num / 100;
			if (v > 99) v = 99;
			return 16'((int'(pwm_period) * v) / 100);
		endfunction

		function void take_tick(logic [15:0] limit, logic signed [7:0] corr);
			pwm_word_t w;
			int unsigned phase_idx [3];
			logic [15:0] cmp;
			w = '0;
			ticks_taken++;
			if (tick_count != 16'hFFFF) tick_count++;
			if (tick_count > limit) begin
				tick_count = 16'd0;
				w.step_taken = 1'b1;
				steps++;
				idx_a = next_index(idx_a);
				idx_b = next_index(idx_b);
				idx_c = next_index(idx_c);
				phase_idx = '{idx_a, idx_b, idx_c};
				for (int p = 0; p < 3; p++) begin
					cmp = duty_compare(phase_idx[p], corr);
					held[2*p]   = (phase_idx[p] < HALF) ? cmp : gate_off;
					held[2*p+1] = (phase_idx[p] < HALF) ? gate_off : cmp;
				end
				if (idx_a == 0 && half_mark != 2'd1) begin
					half_mark = 2'd1;
					w.half_start = 2'd1;
					halves++;
				end else if (idx_a == HALF && half_mark != 2'd2) begin
					half_mark = 2'd2;
					w.half_start = 2'd2;
					halves++;
				end
			end
			w.a_high = held[0];
			w.a_low = held[1];
			w.b_high = held[2];
			w.b_low = held[3];
			w.c_high = held[4];
			w.c_low = held[5];
			w.a_index = 8'(idx_a);
			expected_words.push_back(w);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("%0t ns: %s mismatch, expected %0d actual %0d",
						$time, name, want, got);
			end
		endfunction

		function void check_word(pwm_word_t got);
			pwm_word_t want;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("%0t ns: output word with nothing expected, actual %h",
						$time, got);
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			compare_field("step_taken", want.step_taken, got.step_taken);
			compare_field("phase_a_high", want.a_high, got.a_high);
			compare_field("phase_a_low", want.a_low, got.a_low);
			compare_field("phase_b_high", want.b_high, got.b_high);
			compare_field("phase_b_low", want.b_low, got.b_low);
			compare_field("phase_c_high", want.c_high, got.c_high);
			compare_field("phase_c_low", want.c_low, got.c_low);
			compare_field("half_start", want.half_start, got.half_start);
			compare_field("phase_a_index", want.a_index, got.a_index);
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// ticks_per_step[15:0], correction_percent[23:16]
	logic [23:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// step_taken[0], phase_a_high[16:1], phase_a_low[32:17], phase_b_high[48:33],
	// phase_b_low[64:49], phase_c_high[80:65], phase_c_low[96:81], half_start[98:97],
	// phase_a_index[106:99], zero fill[111:107]
	logic [111:0] m_tdata;
	logic         cfg_we;
	logic         cfg_index;
	logic [15:0]  cfg_data;

	sine_pwm_predictor predictor = new();
	int unsigned cycles;
	int          hold_left;
	bit          hold_done;
	int unsigned ready_mode;

	three_phase_sine_pwm_generator #(.STEPS_PER_CYCLE(STEPS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stall pattern redrawn throughout the run, one long hold-off mid run
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				predictor.check_word(pwm_word_t'(m_tdata));
			if (cycles % 256 == 0)
				ready_mode = $urandom_range(0, 3);
			if (!hold_done && predictor.ticks_taken >= 700) begin
				hold_done = 1'b1;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (ready_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= (cycles % 7) < 3;
					default: m_tready <= $urandom_range(0, 6) != 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycles, predictor.expected_words.size());
			$display("FAIL three_phase_sine_pwm_generator");
			$finish;
		end
	end

	task automatic send_tick(input logic [15:0] limit, input logic [7:0] corr);
		s_tvalid <= 1'b1;
		s_tdata <= {corr, limit};
		do @(posedge clk); while (!s_tready);
		predictor.take_tick(limit, corr);
	endtask

	task automatic pause_sender(input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_words();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (predictor.expected_words.size() != 0);
	endtask

	task automatic program_regs(input logic [15:0] period, input logic [15:0] gate);
		cfg_we <= 1'b1;
		cfg_index <= REG_PWM_PERIOD;
		cfg_data <= period;
		@(posedge clk);
		predictor.write_reg(REG_PWM_PERIOD, period);
		cfg_index <= REG_GATE_OFF;
		cfg_data <= gate;
		@(posedge clk);
		predictor.write_reg(REG_GATE_OFF, gate);
		cfg_we <= 1'b0;
	endtask

	task automatic random_ticks(input int count);
		int sent, burst, pick;
		logic [15:0] limit;
		logic [7:0]  corr;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && sent < count; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) limit = 16'd0;
				else if (pick < 80) limit = 16'($urandom_range(1, 3));
				else if (pick < 85) limit = 16'($urandom_range(4, 20));
				else if (pick < 95) limit = 16'($urandom_range(0, 65535));
				else limit = 16'hFFFF;
				if ($urandom_range(0, 4) == 0) corr = 8'($urandom_range(0, 255));
				else corr = 8'($signed($urandom_range(0, 198)) - 99);
				send_tick(limit, corr);
				sent++;
			end
			pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
		end
	endtask

	initial begin
		logic [15:0] periods [7];
		logic [15:0] gates [7];
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PWM_PERIOD;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: step every tick, correction extremes in and out of range
		send_tick(16'd0, 8'sd0);
		send_tick(16'd0, 8'sd99);
		send_tick(16'd0, -8'sd99);
		send_tick(16'd0, 8'sd127);
		send_tick(16'd0, -8'sd128);
		send_tick(16'd0, 8'sd100);
		send_tick(16'd0, -8'sd100);
		// largest step count never steps; then small and patterned counts with mixed corrections
		send_tick(16'hFFFF, 8'sd0);
		send_tick(16'hFFFF, 8'sd50);
		send_tick(16'hFFFF, -8'sd50);
		send_tick(16'd1, 8'sd50);
		send_tick(16'd1, -8'sd50);
		send_tick(16'd1, -8'sd50);
		send_tick(16'hAAAA, 8'h55);
		send_tick(16'h5555, 8'hAA);
		send_tick(16'd2, 8'sd1);
		drain_words();

		periods = '{16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(2, 65534)),
			16'($urandom_range(0, 65535)), 16'd100, 16'd1000};
		gates = '{16'd0, 16'hFFFF, 16'd1234, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'hFFFF, 16'd0};
		for (int ph = 0; ph < 7; ph++) begin
			program_regs(periods[ph], gates[ph]);
			random_ticks(200);
			drain_words();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d ticks over %0d register settings: %0d steps, %0d half-cycle marks",
			predictor.ticks_taken, predictor.settings, predictor.steps, predictor.halves);
		$display("%0d output words checked, %0d mismatches",
			predictor.words_checked, predictor.errors);
		if (predictor.errors == 0 && predictor.expected_words.size() == 0) begin
			$display("PASS three_phase_sine_pwm_generator");
		end else begin
			$display("FAIL three_phase_sine_pwm_generator");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/tpspwm_pkg.sv
src/tpspwm_scale_unit.sv
src/three_phase_sine_pwm_generator.sv
tb/testbench.sv
